// File: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/rms_pkg.sv
// constants, command codes and control structs of the regret-matching sampler
// no dependencies
package rms_pkg;

   localparam int MAX_ACTIONS = 64;
   localparam int IDX_W       = $clog2(MAX_ACTIONS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int REG_W       = 48;
   localparam int SUM_W       = 56;
   localparam int VAL_W       = 32;
   localparam int FRAC_W      = 32;
   localparam int CMD_W       = 2;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic cfg_wr;
      logic add_rd;
      logic add_wr;
      logic mul_lo;
      logic mul_hi;
      logic thr_add;
      logic fb_res;
      logic scan;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sum_zero;
      logic scan_done;
      logic out_free;
   } status_type;

   // 0 acts as 1, anything above the store size acts as the store size
   function automatic logic [CNT_W-1:0] eff_actions(input logic [6:0] v);
      logic [CNT_W-1:0] r;
      if (v == 7'd0) begin
         r = CNT_W'(1);
      end else if (32'(v) > MAX_ACTIONS) begin
         r = CNT_W'(MAX_ACTIONS);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage

// File: sv/rms_ctrl.sv
// controller state machine of the regret-matching sampler
// depends on rms_pkg
module rms_ctrl import rms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [CMD_W-1:0] req_tuser,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  status_type       status,
   output cmd_type          cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_ADD_RD  = 4'd1;
   localparam logic [3:0] ST_ADD_WR  = 4'd2;
   localparam logic [3:0] ST_SMP_LO  = 4'd3;
   localparam logic [3:0] ST_SMP_FB  = 4'd4;
   localparam logic [3:0] ST_SMP_HI  = 4'd5;
   localparam logic [3:0] ST_SMP_ADD = 4'd6;
   localparam logic [3:0] ST_SCAN    = 4'd7;
   localparam logic [3:0] ST_DONE    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       idle;

   assign idle       = (state_ff == ST_IDLE);
   assign req_tready = idle;
   assign csr_ready  = idle;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.cfg_wr = idle && csr_valid;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (req_tuser)
                  CMD_CLEAR:  cmd.clear = 1'b1;
                  CMD_ADD:    state_in = ST_ADD_RD;
                  CMD_SAMPLE: state_in = ST_SMP_LO;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_RD: begin
            cmd.add_rd = 1'b1;
            state_in   = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SMP_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = status.sum_zero ? ST_SMP_FB : ST_SMP_HI;
         end
         ST_SMP_FB: begin
            cmd.fb_res = 1'b1;
            state_in   = ST_DONE;
         end
         ST_SMP_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SMP_ADD;
         end
         ST_SMP_ADD: begin
            cmd.thr_add = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/rms_dp.sv
// datapath of the regret-matching sampler: regret memory, positive sum,
// threshold multiplier, prefix scan and result register; depends on rms_pkg
module rms_dp import rms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [6:0]            csr_data,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   logic [REG_W-1:0]       mem [MAX_ACTIONS];
   logic [MAX_ACTIONS-1:0] valid_ff;

   logic [IDX_W-1:0]  idx_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [SUM_W-1:0]  sum_ff;

   logic [IDX_W-1:0]  rd_addr;
   logic [REG_W-1:0]  rd_data_ff;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   logic [63:0]       prod_ff;
   logic [SUM_W-1:0]  thr_ff;
   logic [SUM_W-1:0]  prefix_ff;
   logic [CNT_W-1:0]  scan_addr_ff;
   logic [IDX_W-1:0]  res_ff;
   logic              res_fb_ff;

   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_action_ff;
   logic              rsp_fb_ff;

   logic [REG_W-1:0]  old_val;
   logic [REG_W:0]    add_sum;
   logic [REG_W-1:0]  new_val;
   logic [SUM_W-1:0]  old_pos;
   logic [SUM_W-1:0]  new_pos;
   logic              idx_ok;
   logic              wipe;
   logic [31:0]       mul_b;
   logic [SUM_W-1:0]  cand;
   logic              hit;
   logic              last;
   logic [CNT_W-1:0]  fb_val;
   logic [IDX_W-1:0]  n_last;

   assign wipe    = cmd.clear || cmd.cfg_wr;
   assign idx_ok  = ({1'b0, idx_ff} < n_ff);
   assign n_last  = IDX_W'(n_ff - CNT_W'(1));

   // an entry that was never written since the last clear, csr write or reset reads as zero
   assign old_val = rd_valid_ff ? rd_data_ff : '0;

   // saturating add, overflow when the two top bits differ
   assign add_sum = {old_val[REG_W-1], old_val} +
                    {{(REG_W+1-VAL_W){val_ff[VAL_W-1]}}, val_ff};
   always_comb begin
      if (add_sum[REG_W] != add_sum[REG_W-1]) begin
         new_val = add_sum[REG_W] ? {1'b1, {(REG_W-1){1'b0}}} : {1'b0, {(REG_W-1){1'b1}}};
      end else begin
         new_val = add_sum[REG_W-1:0];
      end
   end

   assign old_pos = old_val[REG_W-1] ? '0 : SUM_W'(old_val[REG_W-2:0]);
   assign new_pos = new_val[REG_W-1] ? '0 : SUM_W'(new_val[REG_W-2:0]);

   always_comb begin
      priority if (cmd.add_rd) begin
         rd_addr = idx_ff;
      end else if (cmd.thr_add) begin
         rd_addr = '0;
      end else begin
         rd_addr = scan_addr_ff[IDX_W-1:0];
      end
   end

   // scan step
   assign cand = prefix_ff + old_pos;
   assign hit  = (cand > thr_ff);
   assign last = (rd_idx_ff == n_last);

   // multiplier operand
   always_comb begin
      if (cmd.mul_hi) begin
         mul_b = 32'(sum_ff[SUM_W-1:32]);
      end else if (sum_ff == '0) begin
         mul_b = 32'(n_ff);
      end else begin
         mul_b = sum_ff[31:0];
      end
   end

   assign fb_val = prod_ff[32+CNT_W-1:32];

   assign status.sum_zero  = (sum_ff == '0);
   assign status.scan_done = hit || last;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // regret memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.add_wr && idx_ok) begin
         mem[idx_ff] <= new_val;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      rd_idx_ff   <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset || wipe) begin
         valid_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.add_wr && idx_ok) begin
         valid_ff[idx_ff] <= 1'b1;
         sum_ff           <= sum_ff - old_pos + new_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= CNT_W'(MAX_ACTIONS);
      end else if (cmd.cfg_wr) begin
         n_ff <= eff_actions(csr_data);
      end
   end

   // transaction fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff  <= req_tdata[IDX_W-1:0];
         val_ff  <= req_tdata[IDX_W +: VAL_W];
         frac_ff <= req_tdata[IDX_W+VAL_W +: FRAC_W];
      end
   end

   // threshold = floor(f * sum / 2^32) over two products of one multiplier
   always_ff @(posedge clock) begin
      if (cmd.mul_lo || cmd.mul_hi) begin
         prod_ff <= 64'(frac_ff) * 64'(mul_b);
      end
      if (cmd.mul_hi) begin
         thr_ff <= SUM_W'(prod_ff[63:32]);
      end else if (cmd.thr_add) begin
         thr_ff <= thr_ff + prod_ff[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.thr_add) begin
         prefix_ff    <= '0;
         scan_addr_ff <= CNT_W'(1);
      end else if (cmd.scan) begin
         prefix_ff    <= cand;
         scan_addr_ff <= scan_addr_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fb_res) begin
         res_ff    <= (fb_val >= n_ff) ? n_last : fb_val[IDX_W-1:0];
         res_fb_ff <= 1'b1;
      end else if (cmd.scan && (hit || last)) begin
         res_ff    <= rd_idx_ff;
         res_fb_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_action_ff <= res_ff;
         rsp_fb_ff     <= res_fb_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_action_ff);
   assign rsp_tuser  = rsp_fb_ff;

endmodule

// File: sv/regret_matching_sampler_unit.sv
// top level of the regret-matching sampler: controller plus datapath
// depends on rms_pkg, rms_ctrl, rms_dp
//
//  channel | direction | payload
//  req     | in        | tuser command; tdata action_index, regret_value, random_fraction
//  rsp     | out       | tdata chosen_action; tuser uniform_fallback
//  csr     | in        | data active_actions
//
// clear and unused commands stay idle; add uses a memory read state, then a write state
// sample: multiply-low, then fallback if the positive sum is zero, else multiply-high,
// threshold-add, then a scan of at most n regrets, one per cycle, from the memory port
// reset empties the regret store at once through per-entry valid bits
// a finished result waits in the output register; the next transaction is
// taken meanwhile, and only a sample that finishes into a full register stalls
module regret_matching_sampler_unit import rms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [5:0] action_index, [37:6] regret_value, [69:38] random_fraction
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [5:0] chosen_action
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] uniform_fallback
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [6:0]            csr_data
);

   cmd_type    cmd;
   status_type status;

   rms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .status     (status),
      .cmd        (cmd)
   );

   rms_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: sv/rms_checker.sv
// port-level checks of the regret-matching sampler, bound to the top level
// depends on rms_pkg and assert_macros.svh
`include "assert_macros.svh"

module rms_checker import rms_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [CMD_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic req_take;
   logic rsp_wait;

   assign req_take = req_tvalid && req_tready;
   assign rsp_wait = rsp_tvalid && !rsp_tready;

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a sample keeps the block busy past its acceptance
   `ASSERT_NEXT(a_sample_busy, clock, reset, req_take && req_tuser == CMD_SAMPLE, !req_tready)

   // clear finishes in the cycle it is taken
   `ASSERT_NEXT(a_clear_one, clock, reset, req_take && req_tuser == CMD_CLEAR, req_tready)

   // a new result only follows a busy cycle
   `ASSERT_SAME(a_rsp_after_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind regret_matching_sampler_unit rms_checker u_rms_checker (.*);

// File: verif/testbench.sv
// self-checking testbench for regret_matching_sampler_unit: directed script, large-regret
// runs and random traffic under several action-space sizes, checked by an in-bench predictor
// depends on rms_pkg and the regret_matching_sampler_unit rtl
`timescale 1ns / 100ps

module testbench;
   import rms_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
   localparam logic [31:0] FRAC_MAX = 32'hFFFF_FFFF;
   localparam longint REGRET_CEIL  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint REGRET_FLOOR = -64'sh0000_8000_0000_0000;

   localparam int BIG_ADDS        = 4;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 112;
   localparam int SETTLE_CYCLES   = 100;
   localparam int LONG_HOLD       = 400;
   localparam int CYCLE_LIMIT     = 3_000_000;

   typedef struct packed {
      logic [IDX_W-1:0] action;
      logic             fallback;
   } draw_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      logic [31:0]      val;
      logic [31:0]      frac;
      logic             known;
      logic [IDX_W-1:0] act;
      logic             fb;
   } script_row_type;

   localparam int SCRIPT_LEN = 24;

   // expected draw given only where it follows directly from the state
   script_row_type script [SCRIPT_LEN] = '{
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h0,        1'b1, 6'd0,  1'b1},
      '{CMD_SAMPLE, 6'd0,  32'h0,        FRAC_MAX,     1'b1, 6'd63, 1'b1},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h8000_0000, 1'b1, 6'd32, 1'b1},
      '{CMD_ADD,    6'd63, VAL_MAX,      32'h0,        1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h0,        1'b1, 6'd63, 1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        FRAC_MAX,     1'b1, 6'd63, 1'b0},
      '{CMD_ADD,    6'd0,  VAL_MIN,      32'h0,        1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h0,        1'b1, 6'd63, 1'b0},
      '{CMD_ADD,    6'd10, 32'h1,        32'h0,        1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h0,        1'b1, 6'd10, 1'b0},
      '{CMD_UNUSED, 6'd5,  VAL_MAX,      FRAC_MAX,     1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        FRAC_MAX,     1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h4000_0000, 1'b0, 6'd0,  1'b0},
      '{CMD_ADD,    6'd0,  VAL_MAX,      32'h0,        1'b0, 6'd0,  1'b0},
      '{CMD_ADD,    6'd0,  32'h2,        32'h0,        1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h0,        1'b1, 6'd0,  1'b0},
      '{CMD_ADD,    6'd63, 32'h8000_0001, 32'h0,       1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h0,        1'b0, 6'd0,  1'b0},
      '{CMD_CLEAR,  6'd0,  32'h0,        32'h0,        1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'hC000_0000, 1'b1, 6'd48, 1'b1},
      '{CMD_ADD,    6'd63, 32'h0,        32'h0,        1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        FRAC_MAX,     1'b1, 6'd63, 1'b1},
      '{CMD_ADD,    6'd33, 32'hFFFF_FFFF, 32'h0,       1'b0, 6'd0,  1'b0},
      '{CMD_SAMPLE, 6'd0,  32'h0,        32'h0,        1'b1, 6'd0,  1'b1}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [6:0]            csr_data;

   // predictor state
   logic signed [REG_W-1:0] regret_bank [MAX_ACTIONS];
   logic [SUM_W-1:0]        positive_total;
   logic [6:0]              action_span;

   draw_type pending_draws [$];
   int    fail_count = 0;
   bit    hold_rsp_now = 1'b0;
   bit    rsp_idle_on = 1'b1;
   int    cycle_count = 0;

   regret_matching_sampler_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned live_actions();
      if (action_span == 7'd0) begin
         return 1;
      end else if (int'(action_span) > MAX_ACTIONS) begin
         return MAX_ACTIONS;
      end
      return longint'(action_span);
   endfunction

   function automatic logic [SUM_W-1:0] positive_part(input longint v);
      return (v > 0) ? SUM_W'(v) : '0;
   endfunction

   function automatic void clear_bank();
      foreach (regret_bank[i]) regret_bank[i] = '0;
      positive_total = '0;
   endfunction

   // returns 1 when the command produces a draw
   function automatic bit predict_command(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [31:0] val,
                                          input logic [31:0] frac,
                                          output draw_type draw);
      longint unsigned n;
      longint unsigned f64;
      longint unsigned thr;
      longint unsigned prefix;
      longint unsigned choice;
      longint          old_val;
      longint          new_val;
      n = live_actions();
      f64 = longint'(frac);
      draw = '0;
      case (cmd)
         CMD_CLEAR: begin
            clear_bank();
         end
         CMD_ADD: begin
            if (longint'(idx) < n) begin
               old_val = regret_bank[idx];
               new_val = old_val + longint'($signed(val));
               if (new_val > REGRET_CEIL) new_val = REGRET_CEIL;
               if (new_val < REGRET_FLOOR) new_val = REGRET_FLOOR;
               regret_bank[idx] = new_val[REG_W-1:0];
               positive_total = positive_total - positive_part(old_val)
                                + positive_part(new_val);
            end
         end
         CMD_SAMPLE: begin
            if (positive_total == '0) begin
               choice = (f64 * n) >> 32;
               draw.fallback = 1'b1;
            end else begin
               // threshold = floor(frac * sum / 2^32) split in high and low halves
               thr = f64 * longint'(positive_total >> 32)
                     + ((f64 * longint'(positive_total[31:0])) >> 32);
               prefix = 0;
               choice = n - 1;
               for (int i = 0; i < int'(n); i++) begin
                  prefix = prefix + longint'(positive_part(regret_bank[i]));
                  if (prefix > thr) begin
                     choice = i;
                     break;
                  end
               end
            end
            if (choice >= n) choice = n - 1;
            draw.action = choice[IDX_W-1:0];
            return 1'b1;
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic [31:0] val, input logic [31:0] frac,
                               input bit known, input draw_type known_draw, input int gap);
      draw_type draw;
      bit    gives;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, frac, val, idx};
      do @(posedge clock); while (!req_tready);
      gives = predict_command(cmd, idx, val, frac, draw);
      if (gives) pending_draws.push_back(known ? known_draw : draw);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // block is idle once every draw is back and a further settle wait has gone by
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_span(input logic [6:0] span);
      csr_valid <= 1'b1;
      csr_data  <= span;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      action_span = span;
      clear_bank();
   endtask

   task automatic check_draw();
      draw_type want;
      if (pending_draws.size() == 0) begin
         $error("response transaction with no sample pending: action %0d fallback %0d",
                rsp_tdata[IDX_W-1:0], rsp_tuser);
         fail_count++;
      end else begin
         want = pending_draws.pop_front();
         if (rsp_tdata[IDX_W-1:0] !== want.action) begin
            $error("chosen_action expected %0d actual %0d", want.action, rsp_tdata[IDX_W-1:0]);
            fail_count++;
         end
         if (rsp_tuser !== want.fallback) begin
            $error("uniform_fallback expected %0d actual %0d", want.fallback, rsp_tuser);
            fail_count++;
         end
      end
   endtask

   // result side: random back-pressure plus one long hold when asked
   initial begin : rsp_sink
      int stall_left;
      int pick;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_draw();
         if (hold_rsp_now) begin
            hold_rsp_now = 1'b0;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && rsp_idle_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 97) begin
               stall_left = $urandom_range(10, 40);
            end else if (pick >= 70) begin
               stall_left = $urandom_range(1, 3);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [6:0]       span_plan [NUM_PHASES];
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      logic [31:0]      val;
      logic [31:0]      frac;
      longint unsigned  n;
      int               pick;
      int               gap;
      bit               quiet;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_CLEAR;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      action_span = 7'd64;
      clear_bank();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_command(script[i].cmd, script[i].idx, script[i].val, script[i].frac,
                      script[i].known, '{script[i].act, script[i].fb}, $urandom_range(0, 2));
      end
      settle_block();

      // large regrets of both signs push the positive sum past 32 bits
      send_command(CMD_CLEAR, IDX_W'($urandom), $urandom, $urandom, 1'b0, '0, 0);
      for (int k = 0; k < BIG_ADDS; k++) begin
         send_command(CMD_ADD, 6'd5, VAL_MAX, $urandom, 1'b0, '0, 0);
      end
      send_command(CMD_SAMPLE, IDX_W'($urandom), $urandom, FRAC_MAX, 1'b0, '0, 0);
      send_command(CMD_ADD, 6'd5, 32'h1, $urandom, 1'b0, '0, 0);
      send_command(CMD_ADD, 6'd7, 32'h10, $urandom, 1'b0, '0, 0);
      send_command(CMD_SAMPLE, IDX_W'($urandom), $urandom, 32'h0, 1'b0, '0, 0);
      send_command(CMD_SAMPLE, IDX_W'($urandom), $urandom, FRAC_MAX, 1'b0, '0, 0);
      for (int k = 0; k < BIG_ADDS; k++) begin
         send_command(CMD_ADD, 6'd40, VAL_MIN, $urandom, 1'b0, '0, 0);
      end
      send_command(CMD_SAMPLE, IDX_W'($urandom), $urandom, $urandom, 1'b0, '0, 0);
      send_command(CMD_ADD, 6'd40, VAL_MAX, $urandom, 1'b0, '0, 0);
      send_command(CMD_ADD, 6'd5, VAL_MIN, $urandom, 1'b0, '0, 0);
      send_command(CMD_SAMPLE, IDX_W'($urandom), $urandom, $urandom, 1'b0, '0, 0);
      settle_block();

      span_plan = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd64,
                    7'($urandom_range(3, 63)), 7'($urandom_range(1, 127))};
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_span(span_plan[p]);
         n = live_actions();
         quiet = (p % 3 == 2);
         rsp_idle_on = !quiet;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            idx  = IDX_W'($urandom);
            val  = $urandom;
            frac = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               cmd = CMD_CLEAR;
            end else if (pick < 6) begin
               cmd = CMD_UNUSED;
            end else if (pick < 50) begin
               cmd = CMD_ADD;
               if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, int'(n) - 1));
               pick = $urandom_range(0, 99);
               if (pick < 45) begin
                  val = $urandom_range(0, 32'h000F_FFFF);
               end else if (pick < 70) begin
                  val = 32'h0 - $urandom_range(1, 32'h0007_FFFF);
               end else if (pick < 95) begin
                  val = (pick < 90) ? $urandom : VAL_MAX;
               end else begin
                  val = VAL_MIN;
               end
            end else begin
               cmd = CMD_SAMPLE;
               pick = $urandom_range(0, 99);
               if (pick >= 90) begin
                  frac = FRAC_MAX;
               end else if (pick >= 80) begin
                  frac = 32'h0;
               end
            end
            pick = $urandom_range(0, 99);
            if (quiet || pick < 65) begin
               gap = 0;
            end else if (pick < 95) begin
               gap = $urandom_range(1, 3);
            end else begin
               gap = $urandom_range(8, 40);
            end
            // long result hold while requests keep coming, so the input backs up
            if (p == 2 && k == 40) hold_rsp_now = 1'b1;
            send_command(cmd, idx, val, frac, 1'b0, '0, gap);
         end
         settle_block();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
